// File: hdl/packet_pacer_token_budget_defines.svh
// assertion helpers shared by the pacer rtl
`ifndef PACKET_PACER_TOKEN_BUDGET_DEFINES_SVH
`define PACKET_PACER_TOKEN_BUDGET_DEFINES_SVH

// combinational property checked on every rising clock edge outside reset
`define PPACER_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PPACER_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPACER_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ppacer_pkg.sv
`timescale 1ns / 1ps

package ppacer_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TAG_W     = 16;
  localparam int LEN_W     = 16;
  localparam int ELAPSED_W = 20;
  localparam int RATE_W    = 28;
  localparam int MAXB_W    = 24;
  localparam int LIMIT_W   = 6;
  localparam int KIND_W    = 3;
  localparam int QCNT_W    = 6;
  localparam int BOUT_W    = 25;
  localparam int FRAC_W    = 16;

  // product of elapsed time and rate
  localparam int GAIN_W = ELAPSED_W + RATE_W;
  // budget spans -(2^32) .. 2^40
  localparam int BUD_W  = MAXB_W + FRAC_W + 2;
  // headroom for budget plus gain before the cap
  localparam int SUM_W  = GAIN_W + 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXB  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(8192000);
  localparam logic [MAXB_W-1:0]  MAXB_RESET  = MAXB_W'(625);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '0;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SENT      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd4;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

endpackage

// File: hdl/ppacer_ram.sv
`timescale 1ns / 1ps

module ppacer_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    // read data holds until the next read
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/packet_pacer_token_budget.sv
// packet pacer: descriptor fifo in one ram plus a signed q16 byte budget
// enqueue: result registered from the enq state; no new request is taken until then
// tick: multiply step, add-and-cap step, then one sent result per cycle while
//   the output is not stalled, from the ram read port, and a closing tick done
// output stalls hold the sequencer; rst_n is synchronous, clears pointers,
//   count, budget and drop mode; ram contents are not cleared (no sweep)
`timescale 1ns / 1ps
`include "packet_pacer_token_budget_defines.svh"

module packet_pacer_token_budget
  import ppacer_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  // configuration writes
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,

  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [TAG_W-1:0]            in_packet_tag,
  input  logic [LEN_W-1:0]            in_packet_length,
  input  logic                        in_batch_end,
  input  logic [ELAPSED_W-1:0]        in_elapsed_us,

  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [KIND_W-1:0]           out_kind,
  output logic [TAG_W-1:0]            out_sent_tag,
  output logic [LEN_W-1:0]            out_sent_length,
  output logic                        out_last,
  output logic [QCNT_W-1:0]           out_queue_count,
  output logic                        out_reschedule,
  output logic signed [BOUT_W-1:0]    out_budget_bytes
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ENQ   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  // configuration registers
  logic [RATE_W-1:0]  rate_r;
  logic [MAXB_W-1:0]  maxb_r;
  logic [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_RESET;
      maxb_r  <= MAXB_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RATE:  rate_r  <= cfg_wdata[RATE_W-1:0];
        CFG_MAXB:  maxb_r  <= cfg_wdata[MAXB_W-1:0];
        CFG_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // control state
  logic [2:0]             state_r, state_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic signed [BUD_W-1:0] budget_r, budget_nxt;
  logic                   drop_r, drop_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // captured request, no reset needed
  logic [TAG_W-1:0]       tag_r;
  logic [LEN_W-1:0]       len_r;
  logic                   bend_r;
  logic [ELAPSED_W-1:0]   elapsed_r;
  logic [GAIN_W-1:0]      gain_r;

  // output register payload
  logic [KIND_W-1:0]      o_kind_r, o_kind_nxt;
  logic [TAG_W-1:0]       o_tag_r, o_tag_nxt;
  logic [LEN_W-1:0]       o_len_r, o_len_nxt;
  logic                   o_last_r, o_last_nxt;
  logic                   o_resched_r, o_resched_nxt;

  // ram side
  logic                   ram_wr_en;
  logic                   ram_rd_en;
  logic [PTR_W-1:0]       ram_rd_addr;
  logic [TAG_W+LEN_W-1:0] ram_rd_data;
  logic [TAG_W-1:0]       rd_tag;
  logic [LEN_W-1:0]       rd_len;

  logic                   in_fire;
  logic                   slot_free;
  logic                   emit;
  logic [LIMIT_W:0]       limit_eff;
  logic                   budget_pos;
  logic signed [SUM_W-1:0] sum_w;
  logic signed [SUM_W-1:0] cap_w;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // output register is free, or its result leaves this cycle
  assign slot_free = !out_valid_r || out_ready;

  assign {rd_tag, rd_len} = ram_rd_data;

  // a zero limit or one above the depth means the queue depth
  assign limit_eff = ((limit_r == '0) || ({1'b0, limit_r} > (LIMIT_W+1)'(QUEUE_DEPTH)))
                     ? (LIMIT_W+1)'(QUEUE_DEPTH) : {1'b0, limit_r};

  assign budget_pos = !budget_r[BUD_W-1] && (budget_r != '0);

  // budget plus gain against the cap, all in q16
  assign sum_w = SUM_W'(budget_r) + $signed({2'b00, gain_r});
  assign cap_w = $signed({{(SUM_W-MAXB_W-FRAC_W){1'b0}}, maxb_r, {FRAC_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tag_r     <= in_packet_tag;
      len_r     <= in_packet_length;
      bend_r    <= in_batch_end;
      elapsed_r <= in_elapsed_us;
    end
    // one 20 x 28 multiply, registered before the add
    if (state_r == ST_MUL) gain_r <= elapsed_r * rate_r;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    budget_nxt    = budget_r;
    drop_nxt      = drop_r;
    emit          = 1'b0;
    o_kind_nxt    = o_kind_r;
    o_tag_nxt     = o_tag_r;
    o_len_nxt     = o_len_r;
    o_last_nxt    = o_last_r;
    o_resched_nxt = o_resched_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = head_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = (in_opcode == OP_TICK) ? ST_MUL : ST_ENQ;
      end

      ST_ENQ: begin
        if (slot_free) begin
          emit          = 1'b1;
          o_tag_nxt     = tag_r;
          o_len_nxt     = len_r;
          o_last_nxt    = 1'b1;
          o_resched_nxt = 1'b0;
          if (drop_r) begin
            o_kind_nxt = KIND_DROPPED;
          end else if ({1'b0, count_r} >= (CNT_W+1)'(limit_eff)) begin
            o_kind_nxt = KIND_OVERFLOW;
            drop_nxt   = 1'b1;
          end else begin
            o_kind_nxt = KIND_ACCEPTED;
            ram_wr_en  = 1'b1;
            tail_nxt   = next_slot(tail_r);
            count_nxt  = count_r + CNT_W'(1);
          end
          // batch end always leaves drop mode clear
          if (bend_r) drop_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      ST_MUL: begin
        state_nxt = ST_ADD;
      end

      ST_ADD: begin
        budget_nxt = (sum_w < cap_w) ? BUD_W'(sum_w) : BUD_W'(cap_w);
        // fetch the head descriptor for the first send
        ram_rd_en  = 1'b1;
        state_nxt  = ST_DRAIN;
      end

      ST_DRAIN: begin
        if (slot_free) begin
          emit = 1'b1;
          if ((count_r != '0) && budget_pos) begin
            o_kind_nxt    = KIND_SENT;
            o_tag_nxt     = rd_tag;
            o_len_nxt     = rd_len;
            o_last_nxt    = 1'b0;
            o_resched_nxt = 1'b0;
            budget_nxt    = budget_r -
                            $signed({{(BUD_W-LEN_W-FRAC_W){1'b0}}, rd_len, {FRAC_W{1'b0}}});
            count_nxt     = count_r - CNT_W'(1);
            head_nxt      = next_slot(head_r);
            // prefetch the following descriptor
            ram_rd_en     = 1'b1;
            ram_rd_addr   = head_nxt;
          end else begin
            o_kind_nxt    = KIND_TICK_DONE;
            o_tag_nxt     = '0;
            o_len_nxt     = '0;
            o_last_nxt    = 1'b1;
            o_resched_nxt = (count_r != '0);
            state_nxt     = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      budget_r    <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      budget_r    <= budget_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // count and budget snapshot travel with the result
  logic [QCNT_W-1:0]       o_qcnt_r;
  logic signed [BOUT_W-1:0] o_budget_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      o_kind_r    <= o_kind_nxt;
      o_tag_r     <= o_tag_nxt;
      o_len_r     <= o_len_nxt;
      o_last_r    <= o_last_nxt;
      o_resched_r <= o_resched_nxt;
      o_qcnt_r    <= QCNT_W'(count_nxt);
      // floor of q16 budget is its upper bits
      o_budget_r  <= budget_nxt[FRAC_W+BOUT_W-1:FRAC_W];
    end
  end

  ppacer_ram #(
    .WIDTH(TAG_W + LEN_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_r),
    .wr_data ({tag_r, len_r}),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_kind         = o_kind_r;
  assign out_sent_tag     = o_tag_r;
  assign out_sent_length  = o_len_r;
  assign out_last         = o_last_r;
  assign out_queue_count  = o_qcnt_r;
  assign out_reschedule   = o_resched_r;
  assign out_budget_bytes = o_budget_r;

  // checks
  `PPACER_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH),
                        "queue count above depth")
  `PPACER_ASSERT_IMPL(a_ptr_empty_full,
                      (count_r == '0) || (count_r == CNT_W'(QUEUE_DEPTH)),
                      head_r == tail_r, "pointers disagree with count")
  `PPACER_ASSERT_NEXT(a_one_at_a_time, in_fire, !in_ready,
                      "new request taken while one is in flight")
  `PPACER_ASSERT_IMPL(a_budget_capped, state_r == ST_DRAIN,
                      SUM_W'(budget_r) <= cap_w, "budget above cap while draining")

endmodule
